// ===== hdl/keyboard_scancode_fifo_core_defines.svh =====
// assertion helpers for the keyboard scancode fifo
`ifndef KEYBOARD_SCANCODE_FIFO_CORE_DEFINES_SVH
`define KEYBOARD_SCANCODE_FIFO_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KBSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kbsc check failed");
`define KBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kbsc check failed");
`else
`define KBSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/kbsc_pkg.sv =====
`timescale 1ns / 1ps
package kbsc_pkg;

    localparam int CODE_W = 8;
    localparam int OP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_KEY   = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    // per-cycle control shared by every cell of the row
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CODE_W-1:0] code;
    } t_cell_ctrl;

    // host scancode to scan set 1 make code, unmapped codes give zero
    function automatic logic [CODE_W-1:0] set1_map(input logic [7:0] key);
        logic [CODE_W-1:0] code;
        case (key)
            8'd4:    code = 8'h1e;
            8'd5:    code = 8'h30;
            8'd6:    code = 8'h2e;
            8'd7:    code = 8'h20;
            8'd8:    code = 8'h12;
            8'd9:    code = 8'h21;
            8'd10:   code = 8'h22;
            8'd11:   code = 8'h23;
            8'd12:   code = 8'h17;
            8'd13:   code = 8'h24;
            8'd14:   code = 8'h25;
            8'd15:   code = 8'h26;
            8'd16:   code = 8'h32;
            8'd17:   code = 8'h31;
            8'd18:   code = 8'h18;
            8'd19:   code = 8'h19;
            8'd20:   code = 8'h10;
            8'd21:   code = 8'h13;
            8'd22:   code = 8'h1f;
            8'd23:   code = 8'h14;
            8'd24:   code = 8'h16;
            8'd25:   code = 8'h2f;
            8'd26:   code = 8'h11;
            8'd27:   code = 8'h2d;
            8'd28:   code = 8'h15;
            8'd29:   code = 8'h2c;
            8'd30:   code = 8'h02;
            8'd31:   code = 8'h03;
            8'd32:   code = 8'h04;
            8'd33:   code = 8'h05;
            8'd34:   code = 8'h06;
            8'd35:   code = 8'h07;
            8'd36:   code = 8'h08;
            8'd37:   code = 8'h09;
            8'd38:   code = 8'h0a;
            8'd39:   code = 8'h0b;
            8'd40:   code = 8'h1c;
            8'd41:   code = 8'h01;
            8'd42:   code = 8'h0e;
            8'd43:   code = 8'h0f;
            8'd44:   code = 8'h39;
            8'd57:   code = 8'h3a;
            8'd71:   code = 8'h46;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/keyboard_scancode_fifo_core.sv =====
`timescale 1ns / 1ps
// keyboard scancode fifo core
// input stream: one transfer per port access or key event. tuser carries the
// op (key event, port read, port write), tdata the key code and write byte.
// output stream: exactly one transfer per input transfer, in order, with the
// popped code, the interrupt request flag and the drop flag.
// codes sit in a row of FIFO_DEPTH cells; a read of a nonzero head shifts every
// cell one place toward the head in the same cycle, and a key event loads the
// cell at the fill count.
// the result is registered and valid in the cycle after the input transfer.
// throughput: one item per cycle while the output side takes results.
// if the receiver stalls, the single result register holds and the input
// side stops taking transfers until that result has been taken.
// reset clears every cell, the fill count, the interrupt enable and the output
// valid flag; the block is ready to take items once reset is released.
`include "keyboard_scancode_fifo_core_defines.svh"
module keyboard_scancode_fifo_core
    import kbsc_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // key_code[7:0], write_data[15:8]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // read_data[7:0], irq_request[8], dropped[9]
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_irq_en;
    logic              n_irq_en;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_rdata;
    logic              r_irq;
    logic              r_drop;
    logic [CODE_W-1:0] n_rdata;
    logic              n_irq;
    logic              n_drop;

    logic              w_accept;
    logic              w_full;
    logic              w_pop;
    t_op               w_op;
    t_cell_ctrl        w_ctrl;
    logic [CODE_W-1:0] w_head;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op            = t_op'(i_s_axis_tuser);
    assign w_full          = (r_count == CNT_W'(FIFO_DEPTH));
    // a zero at the head blocks the queue
    assign w_pop           = w_accept && (w_op == OP_READ) && (w_head != '0);

    always_comb begin
        w_ctrl.push = w_accept && (w_op == OP_KEY) && !w_full;
        w_ctrl.pop  = w_pop;
        w_ctrl.code = set1_map(i_s_axis_tdata[7:0]);
    end

    kbsc_chain #(
        .DEPTH (FIFO_DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_count (r_count),
        .o_head  (w_head)
    );

    always_comb begin
        n_count  = r_count;
        n_irq_en = r_irq_en;
        n_rdata  = '0;
        n_irq    = 1'b0;
        n_drop   = 1'b0;
        if (w_accept) begin
            case (w_op)
                OP_KEY: begin
                    if (!w_full) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_irq = r_irq_en;
                end
                OP_READ: begin
                    if (w_pop) begin
                        n_rdata = w_head;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
                OP_WRITE: begin
                    n_irq_en = (i_s_axis_tdata[15:8] != '0);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_irq_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_irq_en <= n_irq_en;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= n_rdata;
            r_irq   <= n_irq;
            r_drop  <= n_drop;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_drop, r_irq, r_rdata};

    `KBSC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    `KBSC_ASSERT_IMPL(a_head_counted, i_clk, i_rst_n, w_head != '0, r_count != '0)
    `KBSC_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, w_pop, r_count == $past(r_count) - CNT_W'(1))
    `KBSC_ASSERT_IMPL(a_drop_full, i_clk, i_rst_n, r_out_valid && r_drop, w_full)

endmodule

// ===== hdl/kbsc_cell.sv =====
`timescale 1ns / 1ps
module kbsc_cell
    import kbsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_wr_sel,
    input  logic [CODE_W-1:0] i_next,
    output logic [CODE_W-1:0] o_data
);

    logic [CODE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_ctrl.pop) begin
            r_data <= i_next;
        end else if (i_ctrl.push && i_wr_sel) begin
            r_data <= i_ctrl.code;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hdl/kbsc_chain.sv =====
`timescale 1ns / 1ps
module kbsc_chain
    import kbsc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CNT_W-1:0]  i_count,
    output logic [CODE_W-1:0] o_head
);

    logic [CODE_W-1:0] w_data [DEPTH+1];

    // a zero enters behind the tail on every shift
    assign w_data[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        kbsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (i_ctrl),
            .i_wr_sel (i_count == CNT_W'(g)),
            .i_next   (w_data[g+1]),
            .o_data   (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import kbsc_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 800;

    // make codes of the letter keys a..z, host codes 4..29
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
        8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14,
        8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       dropped;
    } t_kb_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;   // key_code[7:0], write_data[15:8]
    logic [1:0]  i_s_axis_tuser = '0;   // op[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;        // read_data[7:0], irq_request[8], dropped[9]

    // shadow of the keyboard port state
    logic [7:0]  shadow_codes [QUEUE_DEPTH] = '{default: '0};
    int unsigned shadow_fill = 0;
    logic        shadow_irq_en = 1'b0;

    t_kb_reply   replies_due [$];
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned replies_seen = 0;
    int unsigned drops_due = 0;
    int unsigned codes_popped = 0;
    int unsigned blocked_reads = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sink_stall = 0;
    bit          steady_flow = 1'b0;

    keyboard_scancode_fifo_core #(
        .FIFO_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] set1_make_code(input logic [7:0] key);
        if (key >= 8'd4 && key <= 8'd29) return LETTER_CODES[key - 8'd4];
        // digits 1..9, 0 run in order from code 2
        if (key >= 8'd30 && key <= 8'd39) return key - 8'd28;
        case (key)
            8'd40:   return 8'h1c;
            8'd41:   return 8'h01;
            8'd42:   return 8'h0e;
            8'd43:   return 8'h0f;
            8'd44:   return 8'h39;
            8'd57:   return 8'h3a;
            8'd71:   return 8'h46;
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_kb_reply model_port_access(input logic [1:0] op,
                                                    input logic [7:0] key,
                                                    input logic [7:0] wdata);
        t_kb_reply reply;
        reply = '0;
        case (op)
            OP_KEY: begin
                if (shadow_fill < QUEUE_DEPTH) begin
                    shadow_codes[shadow_fill] = set1_make_code(key);
                    shadow_fill++;
                end else begin
                    reply.dropped = 1'b1;
                    drops_due++;
                end
                reply.irq_request = shadow_irq_en;
            end
            OP_READ: begin
                // a zero at the head stalls the queue for good
                if (shadow_codes[0] != 8'h00) begin
                    reply.read_data = shadow_codes[0];
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                        shadow_codes[i] = shadow_codes[i + 1];
                    shadow_codes[QUEUE_DEPTH - 1] = 8'h00;
                    if (shadow_fill > 0) shadow_fill--;
                    codes_popped++;
                end else begin
                    blocked_reads++;
                end
            end
            OP_WRITE: shadow_irq_en = (wdata != 8'h00);
            default: ;
        endcase
        return reply;
    endfunction

    function automatic int unsigned pick_idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_mapped_key();
        int unsigned r;
        r = $urandom_range(0, 42);
        if (r <= 40) return 8'(4 + r);
        if (r == 41) return 8'd57;
        return 8'd71;
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_access(input logic [1:0] op, input logic [7:0] key,
                               input logic [7:0] wdata);
        int unsigned gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 30) gap = pick_idle_len();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {wdata, key};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        replies_due.push_back(model_port_access(op, key, wdata));
        items_sent++;
    endtask

    task automatic send_key(input logic [7:0] key);
        send_access(OP_KEY, key, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_read();
        send_access(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_write(input logic [7:0] wdata);
        send_access(OP_WRITE, 8'($urandom_range(0, 255)), wdata);
    endtask

    // empty reads, the unused op, the ends of the key table, irq enable
    task automatic test_basic_ops();
        send_read();
        send_access(OP_RESERVED, 8'hff, 8'hff);
        send_access(OP_RESERVED, 8'h00, 8'h00);
        send_key(8'd4);
        send_key(8'd71);
        send_key(8'd44);
        send_key(8'd57);
        send_key(8'd30);
        send_key(8'd39);
        send_key(8'd41);
        send_key(8'd29);
        repeat (9) send_read();
        send_write(8'h80);
        send_key(8'd40);
        send_write(8'h00);
        send_key(8'd43);
        send_write(8'h01);
        send_key(8'd42);
        repeat (3) send_read();
    endtask

    // fill to the top, overflow with mapped and unmapped keys, drain
    task automatic test_overflow();
        steady_flow = 1'b1;
        send_write(8'hff);
        while (shadow_fill < QUEUE_DEPTH) send_key(pick_mapped_key());
        send_key(8'hff);
        send_key(8'h00);
        send_key(8'h80);
        send_key(8'd4);
        send_write(8'h00);
        send_key(8'h7f);
        steady_flow = 1'b0;
        repeat (QUEUE_DEPTH + 1) send_read();
    endtask

    // unmapped keys only go in when the queue is full, so nothing blocks here
    task automatic test_random_traffic(input int unsigned count);
        int unsigned done;
        int unsigned phase_left;
        int unsigned key_pct;
        int unsigned r;
        logic [1:0]  op;
        logic [7:0]  key;
        logic [7:0]  wdata;
        done = 0;
        phase_left = 0;
        key_pct = 45;
        while (done < count) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 120);
                case ($urandom_range(0, 2))
                    0:       key_pct = 70;
                    1:       key_pct = 25;
                    default: key_pct = 45;
                endcase
                steady_flow = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3) op = OP_RESERVED;
            else if (r < 10) op = OP_WRITE;
            else if (r < 10 + key_pct) op = OP_KEY;
            else op = OP_READ;
            if (op == OP_KEY && shadow_fill < QUEUE_DEPTH) key = pick_mapped_key();
            else key = 8'($urandom_range(0, 255));
            if (op == OP_WRITE && $urandom_range(0, 9) < 4) wdata = 8'h00;
            else wdata = 8'($urandom_range(0, 255));
            send_access(op, key, wdata);
            if (op != OP_RESERVED) done++;
            phase_left--;
        end
        steady_flow = 1'b0;
    endtask

    // a stored zero reaches the head and the queue stays stuck behind it
    task automatic test_blocked_head();
        send_write(8'h5a);
        while (shadow_fill > 0) send_read();
        send_key(8'd10);
        send_key(8'd0);
        send_key(8'd20);
        send_key(8'd200);
        repeat (4) send_read();
        while (shadow_fill < QUEUE_DEPTH) send_key(pick_mapped_key());
        send_key(8'd255);
        send_key(8'd5);
        repeat (2) send_read();
        send_write(8'h00);
        send_key(8'd6);
        send_read();
    endtask

    // sink side back-pressure
    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
            sink_stall <= pick_idle_len() - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_kb_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transfer: tdata %04h", o_m_axis_tdata);
            end else begin
                want = replies_due.pop_front();
                if (o_m_axis_tdata[7:0] !== want.read_data ||
                    o_m_axis_tdata[8] !== want.irq_request ||
                    o_m_axis_tdata[9] !== want.dropped) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch at result %0d: read_data exp %02h got %02h",
                                 replies_seen, want.read_data, o_m_axis_tdata[7:0]);
                        $display("  irq_request exp %0b got %0b, dropped exp %0b got %0b",
                                 want.irq_request, o_m_axis_tdata[8],
                                 want.dropped, o_m_axis_tdata[9]);
                    end
                end
            end
        end
    end

    // ends the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, replies_due.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_overflow();
        test_random_traffic(RANDOM_ITEMS);
        test_blocked_head();
        i_s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("sent %0d port accesses and key events, checked %0d results",
                 items_sent, replies_seen);
        $display("%0d codes popped, %0d keys dropped when full, %0d empty or blocked reads",
                 codes_popped, drops_due, blocked_reads);
        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== keyboard_scancode_fifo_core.f =====
+incdir+hdl
hdl/kbsc_pkg.sv
hdl/kbsc_cell.sv
hdl/kbsc_chain.sv
hdl/keyboard_scancode_fifo_core.sv
test/tb_top.sv
